[hw/rtl/mss_pkg.sv]
// Shared constants, types and helpers for the masked signature scanner.
package mss_pkg;

	localparam int MAX_PATTERN_LEN = 16;
	localparam int DEF_PATTERN_LEN = 16;
	localparam int DEF_OFFSET_BITS = 32;
	localparam int HIT_OFFSET_W    = 32;
	localparam int CFG_INDEX_W     = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_MASK  = 2'd2;

	typedef struct packed {
		logic                    hit;
		logic                    first_hit;
		logic [HIT_OFFSET_W-1:0] hit_offset;
		logic                    not_found;
	} result_t;

	// signature byte k; byte 0 sits in pattern_low[7:0], byte 8 in pattern_high[7:0]
	function automatic logic [7:0] sig_byte(input logic [63:0] lo, input logic [63:0] hi,
		input int unsigned k);
		logic [63:0] word;
		word = (k < 8) ? lo : hi;
		return word[(k % 8) * 8 +: 8];
	endfunction

endpackage

[hw/rtl/masked_signature_scanner.sv]
// Masked signature scanner: sliding window compare against a masked byte signature.
// Each result is registered in the result register, or in the skid entry while out_stall holds it.
// Throughput: one byte per cycle while in_stall is low; all window byte compares run in parallel.
// A result register plus one skid entry take one more item while out_stall is high;
// in_stall rises once the skid entry holds an item.
// Reset clears the window, fill count, offset, found flag and the configuration registers.
module masked_signature_scanner #(
	parameter int PATTERN_LEN = mss_pkg::DEF_PATTERN_LEN,
	parameter int OFFSET_BITS = mss_pkg::DEF_OFFSET_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input item channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            scan_start,
	input  logic                            scan_end,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic                            first_hit,
	output logic [mss_pkg::HIT_OFFSET_W-1:0] hit_offset,
	output logic                            not_found,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mss_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_data
);
	import mss_pkg::*;

	localparam int FILL_W = $clog2(PATTERN_LEN + 1);
	localparam int EXT_W  = (OFFSET_BITS > HIT_OFFSET_W) ? OFFSET_BITS : HIT_OFFSET_W;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

	logic [63:0]                pattern_low_q;
	logic [63:0]                pattern_high_q;
	logic [MAX_PATTERN_LEN-1:0] ignore_mask_q;

	logic [7:0]             window_q [PATTERN_LEN];
	logic [FILL_W-1:0]      fill_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic                   found_q;

	logic [7:0]             window_nxt [PATTERN_LEN];
	logic [FILL_W-1:0]      fill_base, fill_nxt;
	logic [OFFSET_BITS-1:0] index, offset_nxt, offs;
	logic [EXT_W-1:0]       offs_ext;
	logic                   found_base, match, hit_now;
	result_t                res_nxt;

	result_t res_q, skid_q;
	logic    res_valid_q, skid_valid_q;
	logic    in_acc, out_acc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			ignore_mask_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PATTERN_LOW:  pattern_low_q  <= cfg_data;
				CFG_PATTERN_HIGH: pattern_high_q <= cfg_data;
				CFG_IGNORE_MASK:  ignore_mask_q  <= cfg_data[MAX_PATTERN_LEN-1:0];
				default: ;
			endcase
		end
	end

	// scan_start wipes history before the byte is shifted in
	always_comb begin
		for (int k = 0; k < PATTERN_LEN - 1; k++)
			window_nxt[k] = scan_start ? 8'h00 : window_q[k + 1];
		window_nxt[PATTERN_LEN - 1] = data_byte;
	end

	always_comb begin
		match = 1'b1;
		for (int k = 0; k < PATTERN_LEN; k++) begin
			if (!ignore_mask_q[k] &&
					window_nxt[k] != sig_byte(pattern_low_q, pattern_high_q, k))
				match = 1'b0;
		end
	end

	always_comb begin
		fill_base  = scan_start ? '0 : fill_q;
		fill_nxt   = (fill_base == FILL_W'(PATTERN_LEN)) ? fill_base : fill_base + FILL_W'(1);
		index      = scan_start ? '0 : offset_q;
		offset_nxt = (index == OFFSET_MAX) ? index : index + OFFSET_BITS'(1);
		found_base = scan_start ? 1'b0 : found_q;
		hit_now    = (fill_nxt == FILL_W'(PATTERN_LEN)) && match;

		offs = '0;
		if (hit_now && index >= OFFSET_BITS'(PATTERN_LEN - 1))
			offs = index - OFFSET_BITS'(PATTERN_LEN - 1);
		offs_ext = EXT_W'(offs);

		res_nxt.hit        = hit_now;
		res_nxt.first_hit  = hit_now && !found_base;
		res_nxt.hit_offset = (offs_ext > EXT_W'({HIT_OFFSET_W{1'b1}})) ?
			{HIT_OFFSET_W{1'b1}} : offs_ext[HIT_OFFSET_W-1:0];
		res_nxt.not_found  = scan_end && !(found_base || hit_now);
	end

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = res_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_LEN; k++)
				window_q[k] <= 8'h00;
			fill_q   <= '0;
			offset_q <= '0;
			found_q  <= 1'b0;
		end else if (in_acc) begin
			window_q <= window_nxt;
			fill_q   <= fill_nxt;
			offset_q <= offset_nxt;
			found_q  <= found_base || hit_now;
		end
	end

	// result register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!res_valid_q || out_acc) begin
				res_valid_q  <= skid_valid_q || in_acc;
				skid_valid_q <= 1'b0;
			end else if (in_acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || out_acc) begin
			if (skid_valid_q)
				res_q <= skid_q;
			else if (in_acc)
				res_q <= res_nxt;
		end else if (in_acc) begin
			skid_q <= res_nxt;
		end
	end

	assign out_valid  = res_valid_q;
	assign hit        = res_q.hit;
	assign first_hit  = res_q.first_hit;
	assign hit_offset = res_q.hit_offset;
	assign not_found  = res_q.not_found;

endmodule

[dv/tb.sv]
// Self-checking testbench for the masked signature scanner: directed and random scans.
`timescale 1ns / 100ps

module tb;
	import mss_pkg::*;

	localparam int PAT_LEN         = DEF_PATTERN_LEN;
	localparam int OFF_BITS        = DEF_OFFSET_BITS;
	localparam int WIN_DEPTH       = MAX_PATTERN_LEN;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_LIMIT     = 5000;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam logic [63:0] OFFSET_LIMIT =
		(OFF_BITS >= 64) ? '1 : ((64'd1 << OFF_BITS) - 64'd1);

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [7:0]              data_byte = 8'd0;
	logic                    scan_start = 1'b0;
	logic                    scan_end = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    hit;
	logic                    first_hit;
	logic [HIT_OFFSET_W-1:0] hit_offset;
	logic                    not_found;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [63:0]             cfg_data = '0;

	masked_signature_scanner #(
		.PATTERN_LEN(PAT_LEN),
		.OFFSET_BITS(OFF_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.scan_start(scan_start),
		.scan_end  (scan_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.first_hit (first_hit),
		.hit_offset(hit_offset),
		.not_found (not_found),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// shadow copy of the scanner's registers and scan state
	logic [63:0] shadow_lo = '0;
	logic [63:0] shadow_hi = '0;
	logic [15:0] shadow_mask = '0;
	logic [7:0]  shadow_window [WIN_DEPTH];
	int          shadow_fill;
	logic [63:0] shadow_index;
	bit          shadow_found;

	result_t pending_results [$];
	int      fail_count = 0;
	int      items_sent = 0;
	int      burst_left = 0;
	bit      hold_off_req = 1'b0;

	function automatic logic [7:0] sig_at(input int k);
		return (k < 8) ? shadow_lo[k*8 +: 8] : shadow_hi[(k-8)*8 +: 8];
	endfunction

	function automatic void clear_scan_state();
		for (int i = 0; i < WIN_DEPTH; i++) shadow_window[i] = 8'd0;
		shadow_fill  = 0;
		shadow_index = '0;
		shadow_found = 1'b0;
	endfunction

	function automatic result_t predict_scan_result(input logic [7:0] d, input bit start,
		input bit is_last);
		result_t     r;
		logic [63:0] idx;
		logic [63:0] offs;
		bit          match;
		r = '0;
		if (start) clear_scan_state();
		for (int i = 0; i < WIN_DEPTH - 1; i++) shadow_window[i] = shadow_window[i+1];
		shadow_window[WIN_DEPTH-1] = d;
		if (shadow_fill < WIN_DEPTH) shadow_fill++;
		idx = shadow_index;
		if (shadow_index < OFFSET_LIMIT) shadow_index++;
		match = (shadow_fill >= PAT_LEN);
		// signature byte 0 lines up with the oldest byte of the active window
		for (int k = 0; k < PAT_LEN; k++)
			if (!shadow_mask[k] && shadow_window[WIN_DEPTH-PAT_LEN+k] != sig_at(k))
				match = 1'b0;
		if (match) begin
			r.hit        = 1'b1;
			r.first_hit  = !shadow_found;
			shadow_found = 1'b1;
			offs = (idx >= 64'(PAT_LEN - 1)) ? idx - 64'(PAT_LEN - 1) : 64'd0;
			r.hit_offset = (offs > 64'hFFFF_FFFF) ? '1 : offs[HIT_OFFSET_W-1:0];
		end
		r.not_found = is_last && !shadow_found;
		return r;
	endfunction

	// accepted bytes go into the predictor; accepted results are checked in order
	always @(posedge clk) begin : scoreboard
		result_t want;
		if (in_valid && !in_stall)
			pending_results.push_back(predict_scan_result(data_byte, scan_start, scan_end));
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no item pending");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					fail_count++;
				end
				if (first_hit !== want.first_hit) begin
					$error("first_hit: expected %0d, got %0d", want.first_hit, first_hit);
					fail_count++;
				end
				if (hit_offset !== want.hit_offset) begin
					$error("hit_offset: expected %0d, got %0d", want.hit_offset, hit_offset);
					fail_count++;
				end
				if (not_found !== want.not_found) begin
					$error("not_found: expected %0d, got %0d", want.not_found, not_found);
					fail_count++;
				end
			end
		end
	end

	// result side: segments of no, light, heavy or alternating stall, plus a long hold
	initial begin : result_stall_gen
		int seg_left;
		int mode;
		seg_left = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(10, 60);
					mode = $urandom_range(0, 3);
				end
				seg_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 2) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= seg_left[0];
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] d, input bit start, input bit is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		data_byte  <= d;
		scan_start <= start;
		scan_end   <= is_last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	// leaves cfg_valid high so that writes can go back to back
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_PATTERN_LOW:  shadow_lo = val;
			CFG_PATTERN_HIGH: shadow_hi = val;
			CFG_IGNORE_MASK:  shadow_mask = val[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
		input logic [63:0] mask_word);
		write_reg(CFG_PATTERN_LOW, lo);
		write_reg(CFG_PATTERN_HIGH, hi);
		write_reg(CFG_IGNORE_MASK, mask_word);
		cfg_valid <= 1'b0;
	endtask

	// random scan; signature copies are planted, some with one cared-for byte spoiled
	task automatic run_scan(input int len, input bit with_start, input bit with_end);
		logic [7:0] scan_bytes [64];
		int plants;
		int p;
		int k;
		for (int i = 0; i < len; i++)
			scan_bytes[i] = ($urandom_range(0, 1) == 0) ? sig_at($urandom_range(0, PAT_LEN - 1))
				: 8'($urandom);
		if (len >= PAT_LEN) begin
			plants = $urandom_range(0, 2);
			repeat (plants) begin
				p = $urandom_range(0, len - PAT_LEN);
				for (int j = 0; j < PAT_LEN; j++)
					if (!shadow_mask[j]) scan_bytes[p+j] = sig_at(j);
				if ($urandom_range(0, 3) == 0) begin
					k = $urandom_range(0, PAT_LEN - 1);
					if (!shadow_mask[k]) scan_bytes[p+k] ^= 8'($urandom_range(1, 255));
				end
			end
		end
		for (int i = 0; i < len; i++)
			send_byte(scan_bytes[i], with_start && i == 0, with_end && i == len - 1);
	endtask

	task automatic test_directed();
		// bytes before any scan_start still fill the window
		send_byte(8'h5A, 1'b0, 1'b0);
		wait_drained();
		write_reg(CFG_UNUSED_IDX, '1);
		// only the last signature byte matters, and it must be 0xFF
		configure(64'h0, 64'hFF00_0000_0000_0000, 64'h7FFF);
		for (int i = 0; i < 15; i++) send_byte(i[0] ? 8'hFF : 8'h00, i == 0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		wait_drained();
		// every byte don't-care: the continued scan hits on its full window, then a fresh one-byte scan gets not_found
		configure('1, '1, 64'hFFFF);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_scans();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mask_word;
		int phase_goal;
		int len;
		for (int phase = 0; phase < 8; phase++) begin
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
			mask_word = {$urandom, $urandom} & 64'hFFFF;
			case (phase)
				0: begin lo = '0; hi = '0; mask_word = '0; end
				1: begin lo = '1; hi = '1; mask_word = '0; end
				2: mask_word = '0;
				3: mask_word = 64'hFFFF;
				4: mask_word = {$urandom, $urandom};
				5: mask_word = 64'hFFFF & ~(64'd1 << $urandom_range(0, 15));
				6: mask_word = 64'd1 << $urandom_range(0, 15);
				default: ;
			endcase
			wait_drained();
			configure(lo, hi, mask_word);
			phase_goal = items_sent + 65;
			while (items_sent < phase_goal) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15)
					: $urandom_range(16, 64);
				run_scan(len, $urandom_range(0, 7) != 0, $urandom_range(0, 3) != 0);
			end
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		configure({$urandom, $urandom}, {$urandom, $urandom}, 64'hFFFF);
		hold_off_req = 1'b1;
		run_scan(40, 1'b1, 1'b0);
		// sender stops until every result is back, then the scan continues
		wait_drained();
		run_scan(24, 1'b0, 1'b1);
	endtask

	task automatic test_long_scan();
		wait_drained();
		configure({$urandom, $urandom}, {$urandom, $urandom}, 64'hFFFF_0000_0000_FFFF);
		run_scan(64, 1'b1, 1'b0);
		run_scan(64, 1'b0, 1'b0);
		run_scan(64, 1'b0, 1'b1);
	endtask

	task automatic finish_run();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("masked_signature_scanner verification clean");
		else
			$display("masked_signature_scanner verification failed");
		$finish;
	endtask

	initial begin
		clear_scan_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_scans();
		test_backpressure();
		test_long_scan();
		finish_run();
	end

	initial begin
		#2ms;
		$display("masked_signature_scanner verification failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/mss_pkg.sv
hw/rtl/masked_signature_scanner.sv
dv/tb.sv
